// File: src/rmpf_pkg.sv
`default_nettype none
package rmpf_pkg;

   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 64;
   localparam int FRAME_BYTES  = PANEL_WIDTH * PANEL_HEIGHT / 8;
   localparam int ADDR_W       = $clog2(FRAME_BYTES);

   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   localparam logic [2:0] REG_AREA_LEFT   = 3'd0;
   localparam logic [2:0] REG_AREA_RIGHT  = 3'd1;
   localparam logic [2:0] REG_AREA_TOP    = 3'd2;
   localparam logic [2:0] REG_AREA_BOTTOM = 3'd3;
   localparam logic [2:0] REG_FINAL_AREA  = 3'd4;

   typedef struct packed {
      logic [6:0] area_left;
      logic [6:0] area_right;
      logic [5:0] area_top;
      logic [5:0] area_bottom;
      logic       final_area;
   } cfg_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic mem_rd;
      logic mem_wr;
      logic next_pix;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic pix_valid;
      logic pix_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: src/rmpf_csr.sv
`default_nettype none
module rmpf_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire [rmpf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire [rmpf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rmpf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output rmpf_pkg::cfg_type                 cfg,
   output logic                              cfg_restart
);
   import rmpf_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in      = cfg_ff;
      cfg_restart = 1'b0;
      if (wr_en) begin
         case (reg_idx)
            REG_AREA_LEFT: begin
               cfg_in.area_left = csr_pwdata[6:0];
               cfg_restart      = 1'b1;
            end
            REG_AREA_RIGHT: begin
               cfg_in.area_right = csr_pwdata[6:0];
               cfg_restart       = 1'b1;
            end
            REG_AREA_TOP: begin
               cfg_in.area_top = csr_pwdata[5:0];
               cfg_restart     = 1'b1;
            end
            REG_AREA_BOTTOM: begin
               cfg_in.area_bottom = csr_pwdata[5:0];
               cfg_restart        = 1'b1;
            end
            REG_FINAL_AREA: begin
               cfg_in.final_area = csr_pwdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_AREA_LEFT:   csr_prdata = {25'd0, cfg_ff.area_left};
         REG_AREA_RIGHT:  csr_prdata = {25'd0, cfg_ff.area_right};
         REG_AREA_TOP:    csr_prdata = {26'd0, cfg_ff.area_top};
         REG_AREA_BOTTOM: csr_prdata = {26'd0, cfg_ff.area_bottom};
         REG_FINAL_AREA:  csr_prdata = {31'd0, cfg_ff.final_area};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.area_left   <= 7'd0;
         cfg_ff.area_right  <= 7'd127;
         cfg_ff.area_top    <= 6'd0;
         cfg_ff.area_bottom <= 6'd63;
         cfg_ff.final_area  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: src/rmpf_ctrl.sv
`default_nettype none
module rmpf_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   output rmpf_pkg::cmd_type  cmd,
   input  rmpf_pkg::sts_type  sts
);
   import rmpf_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_MOD   = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.is_read) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_FIN;
            end else if (sts.pix_valid) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_MOD;
            end else if (sts.pix_last) begin
               state_in = S_FIN;
            end else begin
               cmd.next_pix = 1'b1;
            end
         end
         S_MOD: begin
            cmd.mem_wr = 1'b1;
            if (sts.pix_last) begin
               state_in = S_FIN;
            end else begin
               cmd.next_pix = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr |-> $past(cmd.mem_rd))
      else $error("pixel write without its read");

   a_last_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) && sts.pix_last |=> (state_ff == S_FIN))
      else $error("last pixel did not end the scan");

endmodule
`default_nettype wire

// File: src/rmpf_dp.sv
`default_nettype none
module rmpf_dp (
   input  wire                clock,
   input  wire                reset,
   input  rmpf_pkg::cfg_type  cfg,
   input  wire                cfg_restart,
   input  rmpf_pkg::cmd_type  cmd,
   output rmpf_pkg::sts_type  sts,
   input  wire                req_type,
   input  wire [7:0]          req_pixel_byte,
   input  wire [9:0]          req_read_address,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_area_done,
   output logic               rsp_frame_ready
);
   import rmpf_pkg::*;

   logic [7:0]        mem [FRAME_BYTES];

   logic              type_ff;
   logic [7:0]        byte_ff;
   logic [9:0]        raddr_ff;
   logic [2:0]        bit_ff;
   logic [2:0]        bit_in;
   logic [6:0]        col_ff;
   logic [6:0]        col_in;
   logic [5:0]        row_ff;
   logic [5:0]        row_in;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [7:0]        rdata_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [7:0]        rsp_data_ff;
   logic              rsp_done_ff;
   logic              rsp_ready_ff;

   logic [7:0]        w;
   logic [6:0]        h;
   logic [7:0]        off;
   logic [8:0]        x;
   logic [6:0]        y;
   logic              pix_on;
   logic [ADDR_W-1:0] pix_idx;
   logic [7:0]        mask;
   logic [7:0]        wdata;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [7:0]        col_sum;
   logic [6:0]        row_sum;
   logic              done;
   logic              rd_in_range;
   logic              out_free;

   assign w = (cfg.area_right >= cfg.area_left)
            ? ({1'b0, cfg.area_right} - {1'b0, cfg.area_left} + 8'd1) : 8'd1;
   assign h = (cfg.area_bottom >= cfg.area_top)
            ? ({1'b0, cfg.area_bottom} - {1'b0, cfg.area_top} + 7'd1) : 7'd1;

   assign off     = {1'b0, col_ff} + {5'd0, bit_ff};
   assign x       = {2'd0, cfg.area_left} + {1'b0, off};
   assign y       = {1'b0, cfg.area_top} + {1'b0, row_ff};
   assign pix_on  = byte_ff[3'd7 - bit_ff];
   assign pix_idx = ADDR_W'(32'(y >> 3) * PANEL_WIDTH) + ADDR_W'(x);
   assign mask    = 8'd1 << y[2:0];
   assign wdata   = pix_on ? (rdata_ff | mask) : (rdata_ff & ~mask);

   assign rd_in_range = 32'(raddr_ff) < FRAME_BYTES;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign sts.clear_last = (clr_cnt_ff == ADDR_W'(FRAME_BYTES - 1));
   assign sts.is_read    = type_ff;
   assign sts.pix_valid  = ({1'b0, row_ff} < h) && (off < w)
                         && (32'(x) < PANEL_WIDTH) && (32'(y) < PANEL_HEIGHT);
   assign sts.pix_last   = (bit_ff == 3'd7);
   assign sts.out_free   = out_free;

   assign mem_we   = cmd.clear_step || cmd.mem_wr;
   assign mem_addr = cmd.clear_step ? clr_cnt_ff
                   : (type_ff ? ADDR_W'(raddr_ff) : pix_idx);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= cmd.clear_step ? 8'd0 : wdata;
      end else if (cmd.mem_rd) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_comb begin
      col_sum = {1'b0, col_ff} + 8'd8;
      row_sum = {1'b0, row_ff} + 7'd1;
      col_in  = col_ff;
      row_in  = row_ff;
      done    = 1'b0;
      if (col_sum >= w) begin
         col_in = 7'd0;
         if (row_sum >= h) begin
            row_in = 6'd0;
            done   = 1'b1;
         end else begin
            row_in = row_sum[5:0];
         end
      end else begin
         col_in = col_sum[6:0];
      end
   end

   always_comb begin
      bit_in = bit_ff;
      if (cmd.load) begin
         bit_in = 3'd0;
      end else if (cmd.next_pix) begin
         bit_in = bit_ff + 3'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      if (cmd.load) begin
         type_ff  <= req_type;
         byte_ff  <= req_pixel_byte;
         raddr_ff <= req_read_address;
      end
      if (cmd.finish) begin
         rsp_data_ff  <= (type_ff && rd_in_range) ? rdata_ff : 8'd0;
         rsp_done_ff  <= !type_ff && done;
         rsp_ready_ff <= !type_ff && done && cfg.final_area;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= 7'd0;
         row_ff       <= 6'd0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
         if (cfg_restart) begin
            col_ff <= 7'd0;
            row_ff <= 6'd0;
         end else if (cmd.finish && !type_ff) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_area_done   = rsp_done_ff;
   assign rsp_frame_ready = rsp_ready_ff;

   a_col_in_area: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < w)
      else $error("column cursor beyond area width");

   a_row_in_area: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} < h)
      else $error("row cursor beyond area height");

   a_ready_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready_ff |-> rsp_done_ff && (rsp_data_ff == 8'd0))
      else $error("frame ready without area done");

endmodule
`default_nettype wire

// File: src/row_major_to_page_framebuffer.sv
`default_nettype none
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_type, req_pixel_byte, req_read_address
// rsp      out        rsp_valid / rsp_stall  rsp_read_data, rsp_area_done, rsp_frame_ready
// csr      in         APB-style, pready = 1  area_left .. final_area at 4*i
//
// Pixel byte: one pixel at a time; each pixel inside the area takes a read-modify-write
// through the single frame store port, and pixels outside the area are skipped.
// Frame store read: the load, read and finish states in order.
// After reset the store is swept to zero with req_stall high.
// A result waits in the output register while rsp_stall is high; the next word
// runs meanwhile and holds in its last step until the register frees up.
module row_major_to_page_framebuffer (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_type,
   input  wire [7:0]                        req_pixel_byte,
   input  wire [9:0]                        req_read_address,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [7:0]                       rsp_read_data,
   output logic                             rsp_area_done,
   output logic                             rsp_frame_ready,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [rmpf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [rmpf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rmpf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import rmpf_pkg::*;

   cfg_type cfg;
   logic    cfg_restart;
   cmd_type cmd;
   sts_type sts;

   rmpf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_restart (cfg_restart)
   );

   rmpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   rmpf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cfg_restart      (cfg_restart),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_pixel_byte   (req_pixel_byte),
      .req_read_address (req_read_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_area_done    (rsp_area_done),
      .rsp_frame_ready  (rsp_frame_ready)
   );

endmodule
`default_nettype wire

// File: tb/row_major_to_page_framebuffer_tb.sv
`timescale 1ns / 1ps
module row_major_to_page_framebuffer_tb;
   import rmpf_pkg::*;

   localparam int WORD_TARGET   = 950;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 40;

   localparam logic [2:0] REG_SPARE_LO = 3'd5;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;
   localparam logic       REQ_PIXEL    = 1'b0;
   localparam logic       REQ_READ     = 1'b1;

   typedef struct packed {
      logic [7:0] read_data;
      logic       area_done;
      logic       frame_ready;
   } frame_result_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic                  req_type         = 1'b0;
   logic [7:0]            req_pixel_byte   = '0;
   logic [9:0]            req_read_address = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [7:0]            rsp_read_data;
   logic                  rsp_area_done;
   logic                  rsp_frame_ready;
   logic                  csr_psel         = 1'b0;
   logic                  csr_penable      = 1'b0;
   logic                  csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [7:0]       store_model [FRAME_BYTES];
   cfg_type          area_cfg;
   int               col_pos;
   int               row_pos;
   frame_result_type pending_results [$];
   bit               no_idle = 1'b0;
   int               errors;
   int               words_sent;
   int               reads_sent;
   int               results_checked;
   int               areas_closed;
   int               frames_flagged;
   int               idle_cycles;

   row_major_to_page_framebuffer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_pixel_byte   (req_pixel_byte),
      .req_read_address (req_read_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_area_done    (rsp_area_done),
      .rsp_frame_ready  (rsp_frame_ready),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 29);
   end

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   function automatic int area_span(int lo, int hi);
      return (hi >= lo) ? hi - lo + 1 : 1;
   endfunction

   function automatic frame_result_type predict_word(logic kind, logic [7:0] pixels,
                                                      logic [9:0] addr);
      frame_result_type r;
      int               w;
      int               h;
      int               x;
      int               y;
      int               off;
      int               idx;
      r = '0;
      if (kind == REQ_READ) begin
         r.read_data = (int'(addr) < FRAME_BYTES) ? store_model[addr] : 8'h00;
         return r;
      end
      w = area_span(int'(area_cfg.area_left), int'(area_cfg.area_right));
      h = area_span(int'(area_cfg.area_top), int'(area_cfg.area_bottom));
      y = int'(area_cfg.area_top) + row_pos;
      if (row_pos < h) begin
         for (int b = 0; b < 8; b++) begin
            off = col_pos + b;
            x   = int'(area_cfg.area_left) + off;
            if (off < w && x < PANEL_WIDTH && y < PANEL_HEIGHT) begin
               idx = x + (y / 8) * PANEL_WIDTH;
               if (idx < FRAME_BYTES)
                  store_model[idx][y % 8] = pixels[7 - b];
            end
         end
      end
      col_pos += 8;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) begin
            row_pos = 0;
            r.area_done = 1'b1;
         end
      end
      col_pos &= 'h7f;
      row_pos &= 'h3f;
      r.frame_ready = r.area_done & area_cfg.final_area;
      return r;
   endfunction

   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            errors++;
            $error("result word with no word outstanding");
         end else begin
            want = pending_results.pop_front();
            compare_field("read_data", want.read_data, rsp_read_data);
            compare_field("area_done", want.area_done, rsp_area_done);
            compare_field("frame_ready", want.frame_ready, rsp_frame_ready);
            areas_closed   += want.area_done;
            frames_flagged += want.frame_ready;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("row_major_to_page_framebuffer_tb: done, errors");
         $finish;
      end
   end

   task automatic send_word(logic kind, logic [7:0] pixels, logic [9:0] addr);
      while (!no_idle && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_pixel_byte   <= pixels;
      req_read_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_word(kind, pixels, addr));
      words_sent++;
      if (kind == REQ_READ)
         reads_sent++;
   endtask

   task automatic send_pixels(logic [7:0] pixels);
      send_word(REQ_PIXEL, pixels, 10'($urandom));
   endtask

   task automatic send_read(int addr);
      send_word(REQ_READ, 8'($urandom), 10'(addr));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_access(logic write, logic [2:0] index, logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      logic [31:0] unused;
      drain_results();
      csr_access(1'b1, index, value, unused);
      case (index)
         REG_AREA_LEFT:   area_cfg.area_left   = value[6:0];
         REG_AREA_RIGHT:  area_cfg.area_right  = value[6:0];
         REG_AREA_TOP:    area_cfg.area_top    = value[5:0];
         REG_AREA_BOTTOM: area_cfg.area_bottom = value[5:0];
         REG_FINAL_AREA:  area_cfg.final_area  = value[0];
         default: ;
      endcase
      // restart the area on any bound write
      if (index inside {REG_AREA_LEFT, REG_AREA_RIGHT, REG_AREA_TOP, REG_AREA_BOTTOM}) begin
         col_pos = 0;
         row_pos = 0;
      end
   endtask

   task automatic csr_check(logic [2:0] index);
      logic [31:0] want;
      logic [31:0] mask;
      logic [31:0] got;
      string       name;
      case (index)
         REG_AREA_LEFT: begin
            want = 32'(area_cfg.area_left);   mask = 32'h7f; name = "area_left";
         end
         REG_AREA_RIGHT: begin
            want = 32'(area_cfg.area_right);  mask = 32'h7f; name = "area_right";
         end
         REG_AREA_TOP: begin
            want = 32'(area_cfg.area_top);    mask = 32'h3f; name = "area_top";
         end
         REG_AREA_BOTTOM: begin
            want = 32'(area_cfg.area_bottom); mask = 32'h3f; name = "area_bottom";
         end
         default: begin
            want = 32'(area_cfg.final_area);  mask = 32'h01; name = "final_area";
         end
      endcase
      drain_results();
      csr_access(1'b0, index, 32'($urandom), got);
      compare_field(name, want, got & mask);
   endtask

   task automatic set_area(int left, int right, int top, int bottom, int fin);
      csr_write(REG_AREA_LEFT, left);
      csr_write(REG_AREA_RIGHT, right);
      csr_write(REG_AREA_TOP, top);
      csr_write(REG_AREA_BOTTOM, bottom);
      csr_write(REG_FINAL_AREA, fin);
   endtask

   task automatic test_reset_values();
      for (int i = REG_AREA_LEFT; i <= REG_FINAL_AREA; i++)
         csr_check(3'(i));
      send_read(0);
      send_read(FRAME_BYTES - 1);
   endtask

   task automatic test_directed_cases();
      // one byte fills a single-row area
      set_area(0, 7, 0, 0, 1);
      send_pixels(8'hff);
      send_read(0);
      // inverted bounds collapse to one pixel at the bottom right corner
      set_area(127, 0, 63, 0, 0);
      send_pixels(8'h80);
      send_read(FRAME_BYTES - 1);
      send_pixels(8'h7f);
      send_read(FRAME_BYTES - 1);
      // nine columns: padding bits of the second byte are dropped
      set_area(119, 127, 62, 63, 1);
      send_pixels(8'haa);
      send_pixels(8'hff);
      send_pixels(8'h55);
      send_pixels(8'h80);
      send_read(119 + 7 * PANEL_WIDTH);
      send_read(FRAME_BYTES - 1);
      // final_area and spare writes mid-area keep the cursors
      set_area(0, 15, 8, 8, 0);
      send_pixels(8'hc3);
      csr_write(REG_FINAL_AREA, 1);
      csr_write(REG_SPARE_LO, $urandom);
      csr_write(REG_SPARE_HI, $urandom);
      send_pixels(8'h3c);
      send_read(PANEL_WIDTH);
      send_read(PANEL_WIDTH + 15);
      for (int i = REG_AREA_LEFT; i <= REG_FINAL_AREA; i++)
         csr_check(3'(i));
   endtask

   task automatic test_full_width_burst();
      set_area(0, 127, 32, 35, 1);
      no_idle = 1'b1;
      for (int i = 0; i < 64; i++) begin
         send_pixels(8'($urandom));
         if (i % 16 == 15)
            send_read(4 * PANEL_WIDTH + $urandom_range(PANEL_WIDTH - 1));
      end
      drain_results();
      no_idle = 1'b0;
   endtask

   task automatic test_random_areas();
      int left;
      int right;
      int top;
      int bottom;
      int w;
      int h;
      int n;
      int cut;
      int split;
      int x;
      int y;
      while (words_sent < WORD_TARGET) begin
         left = $urandom_range(127);
         case ($urandom_range(9))
            0: right = $urandom_range(127);
            1: begin
               left  = 0;
               right = 127;
            end
            default: begin
               right = left + $urandom_range(23);
               if (right > 127)
                  right = 127;
            end
         endcase
         top = $urandom_range(63);
         case ($urandom_range(7))
            0: bottom = $urandom_range(63);
            1: begin
               top    = 0;
               bottom = 63;
            end
            default: begin
               bottom = top + $urandom_range(5);
               if (bottom > 63)
                  bottom = 63;
            end
         endcase
         if (area_span(left, right) * area_span(top, bottom) > 1024)
            bottom = top;
         w = area_span(left, right);
         h = area_span(top, bottom);
         n = ((w + 7) / 8) * h;
         cut   = ($urandom_range(7) == 0) ? $urandom_range(n - 1) : n;
         split = ($urandom_range(7) == 0) ? $urandom_range(cut) : -1;
         set_area(left, right, top, bottom, $urandom_range(1));
         if ($urandom_range(3) == 0)
            csr_check(3'($urandom_range(REG_AREA_LEFT, REG_FINAL_AREA)));
         for (int i = 0; i < cut; i++) begin
            if (i == split) begin
               if ($urandom_range(1))
                  csr_write(REG_FINAL_AREA, $urandom_range(1));
               else
                  csr_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
            end
            if ($urandom_range(99) < 12) begin
               if ($urandom_range(1)) begin
                  x = left + $urandom_range(w - 1);
                  y = top + $urandom_range(h - 1);
                  send_read((x > 127 ? 127 : x) + (y / 8) * PANEL_WIDTH);
               end else begin
                  send_read($urandom_range(1023));
               end
            end
            send_pixels(8'($urandom));
         end
      end
   endtask

   initial begin
      foreach (store_model[i])
         store_model[i] = 8'h00;
      area_cfg.area_left   = 7'd0;
      area_cfg.area_right  = 7'd127;
      area_cfg.area_top    = 6'd0;
      area_cfg.area_bottom = 6'd63;
      area_cfg.final_area  = 1'b1;
      col_pos = 0;
      row_pos = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed_cases();
      test_full_width_burst();
      test_random_areas();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $error("%0d result words never arrived", pending_results.size());
      end
      $display("covered %0d words (%0d frame store reads), %0d results checked",
               words_sent, reads_sent, results_checked);
      $display("areas completed: %0d, of which flagged frame_ready: %0d",
               areas_closed, frames_flagged);
      if (errors == 0)
         $display("row_major_to_page_framebuffer_tb: done, clean");
      else
         $display("row_major_to_page_framebuffer_tb: done, errors");
      $finish;
   end

endmodule
